// File: rtl/indexed_scatter_add_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Scatter-add accumulator: assertion macros
// Shared concurrent assertion helpers, clocked, with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SCATTER_ADD_ACCUMULATOR_DEFINES_SVH
`define INDEXED_SCATTER_ADD_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication.
`define ISACC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ISACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/isacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scatter-add accumulator package
// Payload structs, queue entry, state encoding and shared constants.
// ----------------------------------------------------------------------------
package isacc_pkg;

    localparam int ROW_W      = 10;
    localparam int COL_W      = 6;
    localparam int GRAD_W     = 32;
    localparam int ACC_W      = 40;
    localparam int CFG_ROWS_W = 11;
    localparam int CFG_FEAT_W = 7;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(1024);
    localparam logic [CFG_FEAT_W-1:0] FEAT_RESET = CFG_FEAT_W'(64);

    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_RANGE = 2'd1;
    localparam t_status STATUS_SAT   = 2'd2;

    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 1'd1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic                     opcode;
        logic [ROW_W-1:0]         row_index;
        logic [COL_W-1:0]         column_index;
        logic signed [GRAD_W-1:0] grad_value;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum_value;
        t_status                 status;
    } t_out_item;

    // Classified request as it travels through the queue.
    typedef struct packed {
        logic                     opcode;
        logic                     in_range;
        logic [ROW_W-1:0]         row_index;
        logic [COL_W-1:0]         column_index;
        logic signed [GRAD_W-1:0] grad_value;
    } t_job;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } t_back_state;

endpackage

// File: rtl/isacc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module isacc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65536
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: rtl/isacc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scatter-add front end
// Holds the size registers, range-checks each request and pushes it queued.
// ----------------------------------------------------------------------------
module isacc_front
    import isacc_pkg::*;
#(
    parameter int ROWS     = 1024,
    parameter int FEATURES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_in_item              i_item,
    output logic                  o_stall,
    input  logic                  i_queue_full,
    input  logic                  i_clearing,
    output logic                  o_push,
    output t_job                  o_job
);

    logic [CFG_ROWS_W-1:0] r_rows_in_use;
    logic [CFG_FEAT_W-1:0] r_features_in_use;
    logic                  row_ok;
    logic                  col_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use     <= ROWS_RESET;
            r_features_in_use <= FEAT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROWS:     r_rows_in_use     <= i_cfg_data[CFG_ROWS_W-1:0];
                CFG_FEATURES: r_features_in_use <= i_cfg_data[CFG_FEAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Bound by both the programmed size and the built table size.
    assign row_ok = (CFG_ROWS_W'(i_item.row_index) < r_rows_in_use)
                 && (32'(i_item.row_index) < 32'(ROWS));
    assign col_ok = (CFG_FEAT_W'(i_item.column_index) < r_features_in_use)
                 && (32'(i_item.column_index) < 32'(FEATURES));

    assign o_stall = i_queue_full || i_clearing;
    assign o_push  = i_valid && !o_stall;

    always_comb begin
        o_job.opcode       = i_item.opcode;
        o_job.in_range     = row_ok && col_ok;
        o_job.row_index    = i_item.row_index;
        o_job.column_index = i_item.column_index;
        o_job.grad_value   = i_item.grad_value;
    end

endmodule

// File: rtl/isacc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request queue
// Small FIFO that decouples the front end from the read-modify-write engine.
// ----------------------------------------------------------------------------
module isacc_fifo
    import isacc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/isacc_back.sv
`timescale 1ns / 1ps
`include "indexed_scatter_add_accumulator_defines.svh"
// ----------------------------------------------------------------------------
// Scatter-add back end
// Clears the table after reset, then runs read-modify-write per request.
// ----------------------------------------------------------------------------
module isacc_back
    import isacc_pkg::*;
#(
    parameter int ROWS     = 1024,
    parameter int FEATURES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_clearing,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int DEPTH = ROWS * FEATURES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_back_state r_state;
    t_back_state n_state;

    t_job             r_job;
    logic [AW-1:0]    r_clr_addr;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             out_free;
    logic             load_out;
    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_waddr;
    logic [ACC_W-1:0] ram_wdata;
    logic [ACC_W-1:0] ram_rdata;
    logic [AW-1:0]    job_addr;
    logic [ACC_W:0]   sum_wide;
    logic [ACC_W-1:0] sum_sat;
    logic             sat_hi;
    logic             sat_lo;
    t_out_item        result;

    assign job_addr = AW'(32'(r_job.row_index) * 32'(FEATURES) + 32'(r_job.column_index));

    isacc_ram #(
        .WIDTH (ACC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (job_addr),
        .o_rdata (ram_rdata)
    );

    // 41-bit sum; the top two bits disagree only on overflow.
    assign sum_wide = {ram_rdata[ACC_W-1], ram_rdata}
                    + {{(ACC_W + 1 - GRAD_W){r_job.grad_value[GRAD_W-1]}}, r_job.grad_value};
    assign sat_hi  = !sum_wide[ACC_W] &&  sum_wide[ACC_W-1];
    assign sat_lo  =  sum_wide[ACC_W] && !sum_wide[ACC_W-1];
    assign sum_sat = sat_hi ? ACC_MAX : (sat_lo ? ACC_MIN : sum_wide[ACC_W-1:0]);

    always_comb begin
        if (!r_job.in_range) begin
            result.sum_value = '0;
            result.status    = STATUS_RANGE;
        end else if (r_job.opcode == OP_READ) begin
            result.sum_value = ram_rdata;
            result.status    = STATUS_OK;
        end else begin
            result.sum_value = sum_sat;
            result.status    = (sat_hi || sat_lo) ? STATUS_SAT : STATUS_OK;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: if (r_clr_addr == AW'(DEPTH - 1)) n_state = BK_IDLE;
            BK_IDLE:  if (!i_empty) n_state = BK_READ;
            BK_READ:  n_state = BK_EXEC;
            BK_EXEC: begin
                if (out_free) begin
                    n_state = i_empty ? BK_IDLE : BK_READ;
                end
            end
            default:  n_state = BK_CLEAR;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop      = 1'b0;
        o_clearing = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = job_addr;
        ram_wdata  = '0;
        load_out   = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                o_clearing = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
            end
            BK_IDLE: begin
                o_pop = !i_empty;
            end
            BK_READ: begin
                ram_re = 1'b1;
            end
            BK_EXEC: begin
                load_out  = out_free;
                o_pop     = out_free && !i_empty;
                ram_we    = out_free && r_job.in_range;
                ram_wdata = (r_job.opcode == OP_READ) ? '0 : sum_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (load_out) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `ISACC_ASSERT_NOW(a_we_phase, i_clk, i_rst_n, ram_we, (r_state == BK_CLEAR) || (r_state == BK_EXEC))
    `ISACC_ASSERT_NEXT(a_read_then_exec, i_clk, i_rst_n, r_state == BK_READ, r_state == BK_EXEC)
    `ISACC_ASSERT_NOW(a_no_pop_clear, i_clk, i_rst_n, r_state == BK_CLEAR, !o_pop && !r_out_valid)
    `ISACC_ASSERT_NOW(a_sat_bound, i_clk, i_rst_n, r_out_valid && (r_out.status == STATUS_SAT), (r_out.sum_value == ACC_MAX) || (r_out.sum_value == ACC_MIN))

endmodule

// File: rtl/indexed_scatter_add_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed scatter-add accumulator
// ROWS x FEATURES table of saturating Q24.16 accumulators with read-and-clear.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in_item): one request per
//    accumulate or read-and-clear. Each request yields exactly one result on
//    the output channel (o_out_valid / i_out_stall / o_out_item), in order.
//  - Config port (i_cfg_we / i_cfg_index / i_cfg_data) sets rows_in_use and
//    features_in_use; write it only while no request is in flight.
//  - Timing: an accepted request passes the queue, is popped into the job
//    register, then reads the table RAM and is loaded into the result
//    register. The read-modify-write runs one request at a time: a read
//    state, then an execute state whose write lands before the next read is issued.
//  - Reset: the table RAM is swept to zero, one entry a cycle, over all
//    ROWS*FEATURES entries; o_in_stall is high throughout. Size registers
//    return to 1024 and 64.
//  - Receiver stall: the result register holds; the engine waits, the
//    two-entry queue fills and then o_in_stall rises.
// ----------------------------------------------------------------------------
module indexed_scatter_add_accumulator
    import isacc_pkg::*;
#(
    parameter int ROWS     = 1024,
    parameter int FEATURES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item
);

    // Front to queue
    logic push;
    t_job push_job;
    // Queue to back
    logic pop;
    t_job head_job;
    logic q_full;
    logic q_empty;
    // Back end busy with the post-reset clearing sweep
    logic clearing;

    // Front: size registers and range classification of each request.
    isacc_front #(
        .ROWS     (ROWS),
        .FEATURES (FEATURES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_in_valid),
        .i_item       (i_in_item),
        .o_stall      (o_in_stall),
        .i_queue_full (q_full),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_job        (push_job)
    );

    // Two-entry queue lets each side stall on its own.
    isacc_fifo #(
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: table RAM, read-modify-write with saturation, result register.
    isacc_back #(
        .ROWS     (ROWS),
        .FEATURES (FEATURES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: sim/scatter_add_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scatter-add accumulator checker
// Watches the config port and both channels, keeps a shadow accumulator table,
// predicts one result per accepted request and compares in arrival order.
// ----------------------------------------------------------------------------
module scatter_add_checker
    import isacc_pkg::*;
#(
    parameter int ROWS     = 1024,
    parameter int FEATURES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_item,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    longint                acc_shadow [ROWS*FEATURES];
    logic [CFG_ROWS_W-1:0] rows_limit;
    logic [CFG_FEAT_W-1:0] feats_limit;
    t_out_item             expected_sums [$];
    int                    mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Applies one request to the shadow table and returns its result.
    function automatic t_out_item scatter_add_predict(input t_in_item req);
        t_out_item   res;
        int unsigned slot;
        longint      total;
        res.sum_value = '0;
        res.status    = STATUS_OK;
        if (req.row_index >= rows_limit || req.row_index >= ROWS ||
            req.column_index >= feats_limit || req.column_index >= FEATURES) begin
            res.status = STATUS_RANGE;
        end else begin
            slot = req.row_index * FEATURES + req.column_index;
            if (req.opcode == OP_ACCUM) begin
                total = acc_shadow[slot] + longint'($signed(req.grad_value));
                if (total > longint'(ACC_MAX)) begin
                    total      = longint'(ACC_MAX);
                    res.status = STATUS_SAT;
                end else if (total < longint'(ACC_MIN)) begin
                    total      = longint'(ACC_MIN);
                    res.status = STATUS_SAT;
                end
                acc_shadow[slot] = total;
                res.sum_value    = total[ACC_W-1:0];
            end else begin
                res.sum_value    = acc_shadow[slot][ACC_W-1:0];
                acc_shadow[slot] = 0;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            foreach (acc_shadow[k]) acc_shadow[k] = 0;
            rows_limit  = ROWS_RESET;
            feats_limit = FEAT_RESET;
            expected_sums.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_index == CFG_ROWS) begin
                    rows_limit = i_cfg_data[CFG_ROWS_W-1:0];
                end else if (i_cfg_index == CFG_FEATURES) begin
                    feats_limit = i_cfg_data[CFG_FEAT_W-1:0];
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                expected_sums.push_back(scatter_add_predict(i_in_item));
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch($sformatf("unexpected result sum=%0d status=%0d",
                        $signed(i_out_item.sum_value), i_out_item.status));
                end else begin
                    want = expected_sums.pop_front();
                    if (i_out_item.sum_value !== want.sum_value) begin
                        report_mismatch($sformatf("sum_value got %0d exp %0d",
                            $signed(i_out_item.sum_value), $signed(want.sum_value)));
                    end
                    if (i_out_item.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d exp %0d",
                            i_out_item.status, want.status));
                    end
                end
            end
        end
        o_outstanding <= expected_sums.size();
        o_mismatches  <= mismatches;
    end

endmodule

// File: sim/indexed_scatter_add_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scatter-add accumulator testbench
// Drives requests and size writes into the accumulator, shapes back-pressure
// on both channels and gives the verdict; checking sits in the checker.
// ----------------------------------------------------------------------------
module indexed_scatter_add_accumulator_tb;
    import isacc_pkg::*;

    localparam int ROWS         = 1024;
    localparam int FEATURES     = 64;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 8;     // quiet margin after the last result
    localparam int HOLD_CYCLES  = 48;    // long receiver hold-off
    localparam int HAMMER_LEN   = 264;   // enough near-full-scale adds to hit a rail
    // Covers the reset sweep of the whole table and the ~1.1k requests,
    // with a wide margin.
    localparam int TIMEOUT_NS   = 5_000_000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROWS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    t_out_item             out_item;

    int mismatches;
    int outstanding;

    // Back-pressure knobs. The sender's is only read by the stimulus process.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_wanted  = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    // Sizes currently programmed, used to aim requests at the edges.
    int cur_rows  = ROWS;
    int cur_feats = FEATURES;

    always #(CLK_HALF) clk = ~clk;

    indexed_scatter_add_accumulator #(
        .ROWS     (ROWS),
        .FEATURES (FEATURES)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    scatter_add_checker #(
        .ROWS     (ROWS),
        .FEATURES (FEATURES)
    ) sum_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Receiver: random stall at the current rate, except during a requested
    // hold-off, when stall stays up so that the queue fills and the block has
    // to push back on its input.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_wanted) begin
            out_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offers one request, with random idle cycles first. Returns at the edge
    // that takes it, leaving valid high so back-to-back requests never drop it.
    task automatic send_request(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall !== 1'b0);
    endtask

    // Waits until every request has its result, plus a quiet margin.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both size registers, back to back; only while the block is idle.
    task automatic program_sizes(input int rows, input int feat_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROWS;
        cfg_data  <= CFG_DATA_W'(rows);
        @(posedge clk);
        cfg_index <= CFG_FEATURES;
        cfg_data  <= CFG_DATA_W'(feat_data);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_rows  = rows & ((1 << CFG_ROWS_W) - 1);
        cur_feats = feat_data & ((1 << CFG_FEAT_W) - 1);
    endtask

    function automatic t_in_item request(input logic op, input int row, input int col,
                                         input logic [GRAD_W-1:0] grad);
        t_in_item r;
        r.opcode       = op;
        r.row_index    = ROW_W'(row);
        r.column_index = COL_W'(col);
        r.grad_value   = grad;
        return r;
    endfunction

    // Mostly a small hot set, so the same entry comes back often and
    // back-to-back; some full-range indexes; some right at the size limits.
    function automatic t_in_item random_request();
        t_in_item r;
        int       pick;
        r.opcode = ($urandom_range(99) < 25) ? OP_READ : OP_ACCUM;
        pick = $urandom_range(99);
        if (pick < 55) begin
            r.row_index    = ROW_W'($urandom_range(3));
            r.column_index = COL_W'($urandom_range(3));
        end else if (pick < 75) begin
            r.row_index    = ROW_W'($urandom);
            r.column_index = COL_W'($urandom);
        end else begin
            r.row_index    = ROW_W'(cur_rows - int'($urandom_range(1)));
            r.column_index = COL_W'(cur_feats - int'($urandom_range(1)));
        end
        case ($urandom_range(3))
            0: r.grad_value = $urandom;
            1: r.grad_value = $urandom_range(511) - 256;
            2: r.grad_value = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(15)
                                                : 32'h8000_0000 + $urandom_range(15);
            default: r.grad_value = int'($urandom) >>> $urandom_range(31);
        endcase
        return r;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Drives one entry into a rail with near-full-scale adds, steps off the
    // rail once, then reads and clears it.
    task automatic hammer(input int row, input int col, input bit upward);
        logic [GRAD_W-1:0] g;
        repeat (HAMMER_LEN) begin
            g = upward ? 32'h7FFF_FFFF - $urandom_range(255)
                       : 32'h8000_0000 + $urandom_range(255);
            send_request(request(OP_ACCUM, row, col, g));
        end
        send_request(request(OP_ACCUM, row, col, upward ? 32'h8000_0000 : 32'h7FFF_FFFF));
        send_request(request(OP_READ, row, col, $urandom));
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 23;
        recv_idle_pct <= 61;

        // Directed: extremes of grad, cancellation, read of a cleared entry,
        // the far corner, alternating index bit patterns, and the read that
        // ignores its grad. The table sweep after reset holds off the first one.
        send_request(request(OP_ACCUM, 0, 0, 32'h7FFF_FFFF));
        send_request(request(OP_ACCUM, 0, 0, 32'h8000_0000));
        send_request(request(OP_READ, 0, 0, 32'hFFFF_FFFF));
        send_request(request(OP_READ, 0, 0, 32'h0000_0000));
        send_request(request(OP_ACCUM, 1023, 63, 32'hFFFF_FFFF));
        send_request(request(OP_READ, 1023, 63, 32'h7FFF_FFFF));
        send_request(request(OP_ACCUM, 1023, 63, 32'h0000_0001));
        send_request(request(OP_ACCUM, 1023, 63, 32'h1234_5678));
        send_request(request(OP_READ, 1023, 63, 32'h0000_0000));
        send_request(request(OP_ACCUM, 682, 42, 32'hAAAA_AAAA));
        send_request(request(OP_ACCUM, 341, 21, 32'h5555_5555));
        send_request(request(OP_READ, 682, 42, 32'h0000_0000));
        send_request(request(OP_READ, 341, 21, 32'h0000_0000));
        settle();

        // Small table: row and column just past the limits get a range status.
        program_sizes(3, 2);
        send_request(request(OP_ACCUM, 3, 0, 32'h0000_0100));
        send_request(request(OP_READ, 0, 2, 32'h0000_0000));
        send_request(request(OP_ACCUM, 2, 1, -32'sd5));
        send_request(request(OP_ACCUM, 2, 1, -32'sd7));
        send_request(request(OP_READ, 2, 1, 32'h0000_0000));
        settle();

        // Zero rows, then zero features: nothing is in range.
        program_sizes(0, FEATURES);
        send_request(request(OP_ACCUM, 0, 0, 32'h0000_0001));
        send_request(request(OP_READ, 0, 0, 32'h0000_0000));
        settle();
        program_sizes(5, 0);
        send_request(request(OP_READ, 0, 0, 32'h0000_0000));
        send_request(request(OP_ACCUM, 4, 3, 32'h0000_0009));
        settle();

        // Sizes beyond the table, all data bits set: bounded by ROWS/FEATURES.
        program_sizes(2047, 11'h7FF);
        send_request(request(OP_ACCUM, 1023, 63, 32'hFFFF_FFFF));
        send_request(request(OP_READ, 1023, 63, 32'h0000_0000));
        settle();

        // Random, first idling mode.
        program_sizes(ROWS, FEATURES);
        run_random(120);
        hammer(7, 9, 1'b1);
        settle();
        program_sizes(5, 3);
        run_random(100);
        settle();

        // Swap the idling: sender heavy, receiver light.
        send_idle_pct = 61;
        recv_idle_pct <= 23;
        program_sizes(1, 1);
        run_random(60);
        settle();
        program_sizes(2047, 11'h7FF);
        hammer(1023, 63, 1'b0);
        settle();
        program_sizes(0, FEATURES);
        run_random(20);
        settle();
        program_sizes($urandom_range(1, ROWS), $urandom_range(1, FEATURES));
        run_random(100);
        settle();

        // No idling at all, with one long receiver hold-off part way in.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        program_sizes(ROWS, FEATURES);
        run_random(30);
        holds_wanted <= holds_wanted + 1;
        run_random(120);
        settle();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
